// ===== design/rau_pkg.sv =====
// Package for the rational arithmetic unit: operation and status codes,
// sequencer states and default widths. No dependencies.
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH       = 32;
  localparam int RES_NUM_WIDTH     = 64;
  localparam int RES_DEN_WIDTH     = 63;
  localparam int IN_DATA_WIDTH     = 4 * FIELD_WIDTH;
  localparam int OUT_DATA_WIDTH    = 128;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DEN = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_COMB,
    ST_GCD_GO,
    ST_GCD_WAIT,
    ST_DIVN_GO,
    ST_DIVN_WAIT,
    ST_DIVD_GO,
    ST_DIVD_WAIT,
    ST_OUT
  } state_e;

endpackage

// ===== design/rau_mul.sv =====
// Registered unsigned multiplier shared by all cross products.
// Depends on nothing but its width parameter.
module rau_mul #(
  parameter int WIDTH = 32
) (
  input  logic               clk_i,
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  output logic [2*WIDTH-1:0] p_o
);

  logic [2*WIDTH-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*WIDTH)'(a_i) * (2*WIDTH)'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== design/rau_gcd.sv =====
// Binary greatest common divisor, one shift or subtract per cycle.
// Depends on nothing but its width parameter; both operands nonzero at start.
module rau_gcd #(
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  output logic             done_o,
  output logic [WIDTH-1:0] g_o
);

  localparam int KW = $clog2(WIDTH + 1);

  logic             busy_q, done_q;
  logic [WIDTH-1:0] x_q, y_q, g_q;
  logic [KW-1:0]    k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (x_q == '0 || y_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (x_q == '0 || y_q == '0) begin
        g_q <= (x_q | y_q) << k_q;
      end else if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + KW'(1);
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q >= y_q) begin
        x_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end
  end

  assign done_o = done_q;
  assign g_o    = g_q;

endmodule

// ===== design/rau_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its width parameter.
module rau_div #(
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [WIDTH:0]   rem_q;
  logic [WIDTH-1:0] quo_q, dvs_q;
  logic [WIDTH:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q[WIDTH-1:0], quo_q[WIDTH-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_q <= {quo_q[WIDTH-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== design/rational_arith_unit.sv =====
// Rational arithmetic unit: a/b op c/d reduced by the GCD, sign on numerator.
// An item passes through the cross products, the GCD loop and two bit-serial divisions
// to the output register; a zero denominator goes straight to the output and a zero
// numerator skips the GCD and the divisions. One item at a time: input is ready only
// while the sequencer is idle. Reset clears sequencer and output valid.
// Uses rau_pkg, rau_mul, rau_gcd, rau_div.
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // num_a, den_a, num_b, den_b
  input  logic [rau_pkg::IN_DATA_WIDTH-1:0]    s_axis_tdata,
  // func
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // res_num, res_den, zero pad
  output logic [rau_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata,
  // status
  output logic [1:0]                           m_axis_tuser
);

  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;
  localparam int L = 2 * OPERAND_WIDTH;

  state_e state_q, state_d;

  logic [W-1:0] raw_a, raw_b, raw_c, raw_d;
  logic [W-1:0] ma_q, mb_q, mc_q, md_q;
  logic         sa_q, sb_q, sc_q, sd_q;
  func_e        op_q;
  logic         zero_den;
  logic         in_xfer, out_xfer;

  logic [W-1:0] mul_a, mul_b;
  logic [L-1:0] mul_p, p1_q, p2_q, p3_q;
  logic [L-1:0] nmag_q, dmag_q, nmag_c, dmag_c, g_q, qn_q, qd_q;
  logic         nneg_q, nneg_c, dneg_c, s1, s2;

  logic         gcd_start, gcd_done, div_start, div_done;
  logic [L-1:0] gcd_g, div_n, div_q;
  status_e      stat_q;

  logic [RES_NUM_WIDTH-1:0] qn64, lim, fin_num;
  logic                     ovf;

  logic                     out_valid_q;
  logic [RES_NUM_WIDTH-1:0] out_num_q;
  logic [RES_DEN_WIDTH-1:0] out_den_q;
  status_e                  out_stat_q;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  assign raw_a    = s_axis_tdata[W-1:0];
  assign raw_b    = s_axis_tdata[FIELD_WIDTH+W-1:FIELD_WIDTH];
  assign raw_c    = s_axis_tdata[2*FIELD_WIDTH+W-1:2*FIELD_WIDTH];
  assign raw_d    = s_axis_tdata[3*FIELD_WIDTH+W-1:3*FIELD_WIDTH];
  assign zero_den = (raw_b == '0) || (raw_d == '0) ||
                    ((func_e'(s_axis_tuser) == FUNC_DIV) && (raw_c == '0));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  rau_mul #(.WIDTH(W)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  rau_gcd #(.WIDTH(L)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (nmag_q),
    .y_i     (dmag_q),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  rau_div #(.WIDTH(L)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (g_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_xfer) state_d = zero_den ? ST_OUT : ST_MUL1;
      ST_MUL1:      state_d = ST_MUL2;
      ST_MUL2:      state_d = ST_MUL3;
      ST_MUL3:      state_d = ST_MUL4;
      ST_MUL4:      state_d = ST_COMB;
      ST_COMB:      state_d = ST_GCD_GO;
      ST_GCD_GO:    state_d = (nmag_q == '0) ? ST_OUT : ST_GCD_WAIT;
      ST_GCD_WAIT:  if (gcd_done) state_d = ST_DIVN_GO;
      ST_DIVN_GO:   state_d = ST_DIVN_WAIT;
      ST_DIVN_WAIT: if (div_done) state_d = ST_DIVD_GO;
      ST_DIVD_GO:   state_d = ST_DIVD_WAIT;
      ST_DIVD_WAIT: if (div_done) state_d = ST_OUT;
      ST_OUT:       if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a     = mb_q;
    mul_b     = md_q;
    gcd_start = 1'b0;
    div_start = 1'b0;
    div_n     = nmag_q;
    unique case (state_q)
      ST_MUL1: begin
        mul_a = ma_q;
        mul_b = (op_q == FUNC_MUL) ? mc_q : md_q;
      end
      ST_MUL2: begin
        mul_a = mb_q;
        mul_b = (op_q == FUNC_MUL) ? md_q : mc_q;
      end
      ST_GCD_GO:  gcd_start = (nmag_q != '0);
      ST_DIVN_GO: div_start = 1'b1;
      ST_DIVD_GO: begin
        div_start = 1'b1;
        div_n     = dmag_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    s1     = sa_q ^ sd_q;
    s2     = sb_q ^ sc_q ^ (op_q == FUNC_SUB);
    nmag_c = p1_q;
    dmag_c = p2_q;
    nneg_c = sa_q ^ sd_q;
    dneg_c = sb_q ^ sc_q;
    case (op_q) inside
      FUNC_ADD, FUNC_SUB: begin
        dmag_c = p3_q;
        dneg_c = sb_q ^ sd_q;
        if (s1 == s2) begin
          nmag_c = p1_q + p2_q;
          nneg_c = s1;
        end else if (p1_q >= p2_q) begin
          nmag_c = p1_q - p2_q;
          nneg_c = s1;
        end else begin
          nmag_c = p2_q - p1_q;
          nneg_c = s2;
        end
      end
      FUNC_MUL: begin
        nneg_c = sa_q ^ sc_q;
        dneg_c = sb_q ^ sd_q;
      end
      default: begin
      end
    endcase
    nneg_c = (nneg_c ^ dneg_c) && (nmag_c != '0);
  end

  assign qn64    = RES_NUM_WIDTH'(qn_q);
  assign lim     = nneg_q ? {1'b1, {(RES_NUM_WIDTH-1){1'b0}}}
                          : {1'b0, {(RES_NUM_WIDTH-1){1'b1}}};
  assign ovf     = qn64 > lim;
  assign fin_num = nneg_q ? (~qn64 + RES_NUM_WIDTH'(1)) : qn64;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= func_e'(s_axis_tuser);
      ma_q   <= mag(raw_a);
      mb_q   <= mag(raw_b);
      mc_q   <= mag(raw_c);
      md_q   <= mag(raw_d);
      sa_q   <= raw_a[W-1];
      sb_q   <= raw_b[W-1];
      sc_q   <= raw_c[W-1];
      sd_q   <= raw_d[W-1];
      stat_q <= zero_den ? STATUS_ZERO_DEN : STATUS_OK;
    end
    if (state_q == ST_MUL2) p1_q <= mul_p;
    if (state_q == ST_MUL3) p2_q <= mul_p;
    if (state_q == ST_MUL4) p3_q <= mul_p;
    if (state_q == ST_COMB) begin
      nmag_q <= nmag_c;
      dmag_q <= dmag_c;
      nneg_q <= nneg_c;
    end
    if (state_q == ST_GCD_GO) begin
      qn_q <= '0;
      qd_q <= L'(1);
    end
    if (state_q == ST_GCD_WAIT && gcd_done) g_q <= gcd_g;
    if (state_q == ST_DIVN_WAIT && div_done) qn_q <= div_q;
    if (state_q == ST_DIVD_WAIT && div_done) qd_q <= div_q;
    if (state_q == ST_DIVD_GO && ovf) stat_q <= STATUS_OVERFLOW;
    if (state_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
      if (stat_q == STATUS_OK) begin
        out_num_q <= fin_num;
        out_den_q <= RES_DEN_WIDTH'(qd_q);
      end else begin
        out_num_q <= '0;
        out_den_q <= RES_DEN_WIDTH'(1);
      end
      out_stat_q <= stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_WIDTH-RES_NUM_WIDTH-RES_DEN_WIDTH){1'b0}},
                          out_den_q, out_num_q};
  assign m_axis_tuser  = out_stat_q;

`ifndef SYNTHESIS
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("accepted a transfer while busy");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != STATUS_OK) |->
      (m_axis_tdata[63:0] == '0 && m_axis_tdata[126:64] == 63'd1))
    else $error("error result carries nonzero fields");

  a_zero_num_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[63:0] == '0) |-> m_axis_tdata[126:64] == 63'd1)
    else $error("zero numerator without unit denominator");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[126:64] != '0)
    else $error("zero denominator on output");
`endif

endmodule
